FILE: sv/dtq_pkg.sv
// Shared types and constants for the delta-list timeout queue.
// Beat structs, mode and status codes, sequencer states. No dependencies.
package dtq_pkg;

	localparam int TIME_W    = 16;
	localparam int ID_W      = 8;
	localparam int MODE_W    = 2;
	localparam int STAT_W    = 2;
	localparam int CNT_OUT_W = 5;

	// Request modes (any other code behaves as a peek)
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PEEK   = 2'd2;

	// Response status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [TIME_W-1:0] delay;
		logic [ID_W-1:0]   msg_id;
	} in_beat_t;

	typedef struct packed {
		logic [STAT_W-1:0]    status;
		logic [ID_W-1:0]      popped_id;
		logic [TIME_W-1:0]    popped_delta;
		logic                 head_valid;
		logic [ID_W-1:0]      head_id;
		logic [TIME_W-1:0]    head_delta;
		logic [CNT_OUT_W-1:0] entry_count;
	} out_beat_t;

	// Write enables of the three node field memories
	typedef struct packed {
		logic delta;
		logic id;
		logic link;
	} node_we_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ALLOC,
		ST_RDNX,
		ST_CMP,
		ST_WR1,
		ST_WR2,
		ST_POPLINK,
		ST_POPHEAD,
		ST_RESP
	} state_t;

	// Where an insert lands in the list
	typedef enum logic [1:0] {
		KIND_EMPTY,
		KIND_FRONT,
		KIND_TAIL,
		KIND_MID
	} kind_t;

endpackage

FILE: sv/dtq_node_mem.sv
// Node storage: delta, id and link memories, one read port shared by all three.
// Read data is registered. Depends on dtq_pkg.
module dtq_node_mem #(
	parameter int CAPACITY = 16
) (
	input  logic                            clk,
	input  dtq_pkg::node_we_t               we,
	input  logic [$clog2(CAPACITY)-1:0]     delta_addr,
	input  logic [dtq_pkg::TIME_W-1:0]      delta_wdata,
	input  logic [dtq_pkg::ID_W-1:0]        id_wdata,
	input  logic [$clog2(CAPACITY)-1:0]     link_addr,
	input  logic [$clog2(CAPACITY)-1:0]     link_wdata,
	input  logic [$clog2(CAPACITY)-1:0]     rd_addr,
	output logic [dtq_pkg::TIME_W-1:0]      rd_delta,
	output logic [dtq_pkg::ID_W-1:0]        rd_id,
	output logic [$clog2(CAPACITY)-1:0]     rd_link
);
	import dtq_pkg::*;

	localparam int SLOT_W = $clog2(CAPACITY);

	logic [TIME_W-1:0] delta_mem [CAPACITY];
	logic [ID_W-1:0]   id_mem    [CAPACITY];
	logic [SLOT_W-1:0] link_mem  [CAPACITY];

	// Write delta and id at one address and link at its own address
	always_ff @(posedge clk) begin
		if (we.delta) begin
			delta_mem[delta_addr] <= delta_wdata;
		end
		if (we.id) begin
			id_mem[delta_addr] <= id_wdata;
		end
		if (we.link) begin
			link_mem[link_addr] <= link_wdata;
		end
	end

	// Read the whole node at one address
	always_ff @(posedge clk) begin
		rd_delta <= delta_mem[rd_addr];
		rd_id    <= id_mem[rd_addr];
		rd_link  <= link_mem[rd_addr];
	end

endmodule

FILE: sv/dtq_free_stack.sv
// Free-slot stack indexed by the entry count, with a high-water mark.
// Entries at or above the mark were never pushed and read as their own index.
// Depends on dtq_pkg.
module dtq_free_stack #(
	parameter int CAPACITY = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [$clog2(CAPACITY+1)-1:0]     count,
	input  logic                              alloc_take,
	input  logic                              push_en,
	input  logic [$clog2(CAPACITY)-1:0]       push_idx,
	input  logic [$clog2(CAPACITY)-1:0]       push_slot,
	output logic [$clog2(CAPACITY)-1:0]       alloc_slot
);
	import dtq_pkg::*;

	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY+1);

	logic [SLOT_W-1:0] stack_mem [CAPACITY];
	logic [SLOT_W-1:0] rdata_s1;
	logic [CNT_W-1:0]  mark_q;

	// Push a freed slot; read the top for the next allocation
	always_ff @(posedge clk) begin
		if (push_en) begin
			stack_mem[push_idx] <= push_slot;
		end
		rdata_s1 <= stack_mem[count[SLOT_W-1:0]];
	end

	// Advance the high-water mark when a fresh slot is handed out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= '0;
		end else if (alloc_take && (count == mark_q)) begin
			mark_q <= mark_q + CNT_W'(1);
		end
	end

	assign alloc_slot = (count == mark_q) ? count[SLOT_W-1:0] : rdata_s1;

endmodule

FILE: sv/dtq_ctrl.sv
// Sequencer for the delta-list queue: accepts request beats, walks the list
// through the node memory, writes back and registers one response beat.
// Depends on dtq_pkg; drives dtq_node_mem and dtq_free_stack.
module dtq_ctrl #(
	parameter int CAPACITY = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  dtq_pkg::in_beat_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output dtq_pkg::out_beat_t                out_data,
	output dtq_pkg::node_we_t                 mem_we,
	output logic [$clog2(CAPACITY)-1:0]       mem_delta_addr,
	output logic [dtq_pkg::TIME_W-1:0]        mem_delta_wdata,
	output logic [dtq_pkg::ID_W-1:0]          mem_id_wdata,
	output logic [$clog2(CAPACITY)-1:0]       mem_link_addr,
	output logic [$clog2(CAPACITY)-1:0]       mem_link_wdata,
	output logic [$clog2(CAPACITY)-1:0]       mem_rd_addr,
	input  logic [dtq_pkg::TIME_W-1:0]        mem_rd_delta,
	input  logic [dtq_pkg::ID_W-1:0]          mem_rd_id,
	input  logic [$clog2(CAPACITY)-1:0]       mem_rd_link,
	output logic [$clog2(CAPACITY+1)-1:0]     fs_count,
	output logic                              fs_take,
	output logic                              fs_push,
	output logic [$clog2(CAPACITY)-1:0]       fs_push_idx,
	output logic [$clog2(CAPACITY)-1:0]       fs_push_slot,
	input  logic [$clog2(CAPACITY)-1:0]       fs_alloc_slot
);
	import dtq_pkg::*;

	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY+1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	state_t            state_q, state_d;
	in_beat_t          op_q;
	kind_t             kind_q, kind_c;
	logic [SLOT_W-1:0] slot_q, it_q, nx_q, head_q, tail_q;
	logic [TIME_W-1:0] cur_q, gap_q, nxd_q, total_q, head_delta_q;
	logic [ID_W-1:0]   head_id_q, pop_id_q;
	logic [TIME_W-1:0] pop_delta_q;
	logic [STAT_W-1:0] status_q;
	logic [CNT_W-1:0]  count_q;
	out_beat_t         out_q, resp_c;
	logic              out_valid_q;

	logic              accept, out_free, list_empty, is_full;
	logic [TIME_W:0]   sum_c;
	logic              stop_c;
	logic [TIME_W-1:0] gap_c;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign list_empty = (count_q == '0);
	assign is_full    = (count_q >= CAP_CNT);
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	// Walk step: running absolute time of the candidate successor
	assign sum_c  = {1'b0, cur_q} + {1'b0, mem_rd_delta};
	assign stop_c = (sum_c >= {1'b0, op_q.delay});
	assign gap_c  = op_q.delay - cur_q;

	// Classify the insert position from the cached head and running total
	always_comb begin
		if (list_empty) begin
			kind_c = KIND_EMPTY;
		end else if (op_q.delay <= head_delta_q) begin
			kind_c = KIND_FRONT;
		end else if (op_q.delay > total_q) begin
			kind_c = KIND_TAIL;
		end else begin
			kind_c = KIND_MID;
		end
	end

	// Response as seen after the step
	always_comb begin
		resp_c              = '0;
		resp_c.status       = status_q;
		resp_c.popped_id    = pop_id_q;
		resp_c.popped_delta = pop_delta_q;
		resp_c.head_valid   = !list_empty;
		resp_c.head_id      = list_empty ? '0 : head_id_q;
		resp_c.head_delta   = list_empty ? '0 : head_delta_q;
		resp_c.entry_count  = CNT_OUT_W'(count_q);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_data.mode)
						MODE_INSERT: state_d = is_full ? ST_RESP : ST_ALLOC;
						MODE_POP: begin
							if (count_q > CNT_W'(1)) begin
								state_d = ST_POPLINK;
							end else begin
								state_d = ST_RESP;
							end
						end
						default: state_d = ST_RESP;
					endcase
				end
			end
			ST_ALLOC:   state_d = (kind_c == KIND_MID) ? ST_RDNX : ST_WR1;
			ST_RDNX:    state_d = ST_CMP;
			ST_CMP:     state_d = stop_c ? ST_WR1 : ST_CMP;
			ST_WR1: begin
				if (kind_q == KIND_EMPTY || kind_q == KIND_TAIL) begin
					state_d = ST_RESP;
				end else begin
					state_d = ST_WR2;
				end
			end
			ST_WR2:     state_d = ST_RESP;
			ST_POPLINK: state_d = ST_POPHEAD;
			ST_POPHEAD: state_d = ST_RESP;
			ST_RESP:    state_d = out_free ? ST_IDLE : ST_RESP;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Memory and free-stack controls
	always_comb begin
		mem_we          = '0;
		mem_delta_addr  = slot_q;
		mem_delta_wdata = op_q.delay;
		mem_id_wdata    = op_q.msg_id;
		mem_link_addr   = slot_q;
		mem_link_wdata  = slot_q;
		mem_rd_addr     = head_q;
		fs_take         = 1'b0;
		fs_push         = 1'b0;
		fs_push_idx     = SLOT_W'(count_q - CNT_W'(1));
		fs_push_slot    = head_q;
		case (state_q)
			ST_IDLE: begin
				fs_push = accept && (in_data.mode == MODE_POP) && !list_empty;
			end
			ST_ALLOC: begin
				fs_take = 1'b1;
			end
			ST_RDNX, ST_CMP, ST_POPLINK: begin
				mem_rd_addr = mem_rd_link;
			end
			ST_WR1: begin
				mem_we = '{delta: 1'b1, id: 1'b1, link: 1'b1};
				case (kind_q)
					KIND_FRONT: mem_link_wdata = head_q;
					KIND_TAIL: begin
						mem_delta_wdata = op_q.delay - total_q;
						mem_link_addr   = tail_q;
					end
					KIND_MID: begin
						mem_delta_wdata = gap_q;
						mem_link_addr   = it_q;
					end
					default: ;
				endcase
			end
			ST_WR2: begin
				mem_we.delta = 1'b1;
				if (kind_q == KIND_FRONT) begin
					mem_delta_addr  = head_q;
					mem_delta_wdata = head_delta_q - op_q.delay;
				end else begin
					mem_delta_addr  = nx_q;
					mem_delta_wdata = nxd_q;
					mem_we.link     = 1'b1;
					mem_link_wdata  = nx_q;
				end
			end
			default: ;
		endcase
	end

	assign fs_count = count_q;

	// Control registers: state, list ends, count, running total, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// raise valid as the response register loads, drop it once the beat leaves
			if (state_q == ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					// drop the head and rebase the running total
					if (accept && (in_data.mode == MODE_POP) && !list_empty) begin
						count_q <= count_q - CNT_W'(1);
						if (count_q == CNT_W'(1)) begin
							head_q  <= '0;
							tail_q  <= '0;
							total_q <= '0;
						end else begin
							total_q <= total_q - head_delta_q;
						end
					end
				end
				ST_WR1: begin
					if (kind_q == KIND_EMPTY) begin
						head_q  <= slot_q;
						tail_q  <= slot_q;
						total_q <= op_q.delay;
						count_q <= count_q + CNT_W'(1);
					end else if (kind_q == KIND_TAIL) begin
						tail_q  <= slot_q;
						total_q <= op_q.delay;
						count_q <= count_q + CNT_W'(1);
					end
				end
				ST_WR2: begin
					if (kind_q == KIND_FRONT) begin
						head_q <= slot_q;
					end
					count_q <= count_q + CNT_W'(1);
				end
				ST_POPLINK: begin
					head_q <= mem_rd_link;
				end
				default: ;
			endcase
		end
	end

	// Payload registers: request, walk cursor, head cache, response fields
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q <= in_data;
					if (in_data.mode == MODE_INSERT && is_full) begin
						status_q <= STAT_FULL;
					end else if (in_data.mode == MODE_POP && list_empty) begin
						status_q <= STAT_EMPTY;
					end else begin
						status_q <= STAT_OK;
					end
					if (in_data.mode == MODE_POP && !list_empty) begin
						pop_id_q    <= head_id_q;
						pop_delta_q <= head_delta_q;
					end else begin
						pop_id_q    <= '0;
						pop_delta_q <= '0;
					end
				end
			end
			ST_ALLOC: begin
				slot_q <= fs_alloc_slot;
				kind_q <= kind_c;
				it_q   <= head_q;
				cur_q  <= head_delta_q;
			end
			ST_RDNX: begin
				nx_q <= mem_rd_link;
			end
			ST_CMP: begin
				// stop ahead of the first entry not earlier than the new one
				if (stop_c) begin
					gap_q <= gap_c;
					nxd_q <= mem_rd_delta - gap_c;
				end else begin
					cur_q <= sum_c[TIME_W-1:0];
					it_q  <= nx_q;
					nx_q  <= mem_rd_link;
				end
			end
			ST_WR1: begin
				if (kind_q == KIND_EMPTY) begin
					head_delta_q <= op_q.delay;
					head_id_q    <= op_q.msg_id;
				end
			end
			ST_WR2: begin
				if (kind_q == KIND_FRONT) begin
					head_delta_q <= op_q.delay;
					head_id_q    <= op_q.msg_id;
				end
			end
			ST_POPHEAD: begin
				head_delta_q <= mem_rd_delta;
				head_id_q    <= mem_rd_id;
			end
			ST_RESP: begin
				if (out_free) begin
					out_q <= resp_c;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: sv/delta_timeout_queue.sv
// Top level of the delta-list timeout queue: sequencer, node memory, free stack.
// Depends on dtq_pkg, dtq_node_mem, dtq_free_stack and dtq_ctrl.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------
//   in      | sink      | in_valid / in_ready  | in_data  (in_beat_t)
//   out     | source    | out_valid / out_ready| out_data (out_beat_t)
//
// One request beat at a time. Peek goes straight to the response register. Pop
// reads the node memory twice when entries remain, the link and then the fields
// of the new head. Insert allocates a slot and writes the node at the head or tail;
// in the middle it first walks the list entry by entry through the one read port of
// the node memory. Reset empties the queue at once; no clearing pass. A waiting
// response does not block the next request beat, only the next response.
module delta_timeout_queue #(
	parameter int CAPACITY = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dtq_pkg::in_beat_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output dtq_pkg::out_beat_t  out_data
);
	import dtq_pkg::*;

	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY+1);

	node_we_t          mem_we;
	logic [SLOT_W-1:0] mem_delta_addr, mem_link_addr, mem_link_wdata, mem_rd_addr;
	logic [TIME_W-1:0] mem_delta_wdata, mem_rd_delta;
	logic [ID_W-1:0]   mem_id_wdata, mem_rd_id;
	logic [SLOT_W-1:0] mem_rd_link;
	logic [CNT_W-1:0]  fs_count;
	logic              fs_take, fs_push;
	logic [SLOT_W-1:0] fs_push_idx, fs_push_slot, fs_alloc_slot;

	dtq_node_mem #(.CAPACITY(CAPACITY)) u_node_mem (
		.clk         (clk),
		.we          (mem_we),
		.delta_addr  (mem_delta_addr),
		.delta_wdata (mem_delta_wdata),
		.id_wdata    (mem_id_wdata),
		.link_addr   (mem_link_addr),
		.link_wdata  (mem_link_wdata),
		.rd_addr     (mem_rd_addr),
		.rd_delta    (mem_rd_delta),
		.rd_id       (mem_rd_id),
		.rd_link     (mem_rd_link)
	);

	dtq_free_stack #(.CAPACITY(CAPACITY)) u_free_stack (
		.clk        (clk),
		.arst_n     (arst_n),
		.count      (fs_count),
		.alloc_take (fs_take),
		.push_en    (fs_push),
		.push_idx   (fs_push_idx),
		.push_slot  (fs_push_slot),
		.alloc_slot (fs_alloc_slot)
	);

	dtq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_data        (out_data),
		.mem_we          (mem_we),
		.mem_delta_addr  (mem_delta_addr),
		.mem_delta_wdata (mem_delta_wdata),
		.mem_id_wdata    (mem_id_wdata),
		.mem_link_addr   (mem_link_addr),
		.mem_link_wdata  (mem_link_wdata),
		.mem_rd_addr     (mem_rd_addr),
		.mem_rd_delta    (mem_rd_delta),
		.mem_rd_id       (mem_rd_id),
		.mem_rd_link     (mem_rd_link),
		.fs_count        (fs_count),
		.fs_take         (fs_take),
		.fs_push         (fs_push),
		.fs_push_idx     (fs_push_idx),
		.fs_push_slot    (fs_push_slot),
		.fs_alloc_slot   (fs_alloc_slot)
	);

endmodule
